### rtl/tws_pkg.sv
// Shared types and codes of the timed window scheduler.
package tws_pkg;

   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_WITHDRAW = 3'd1;
   localparam logic [2:0] OP_ADVANCE  = 3'd2;
   localparam logic [2:0] OP_PAUSE    = 3'd3;
   localparam logic [2:0] OP_PROPS    = 3'd4;

   localparam logic [2:0] EV_STARTED  = 3'd0;
   localparam logic [2:0] EV_FINISHED = 3'd1;
   localparam logic [2:0] EV_PAUSED   = 3'd2;
   localparam logic [2:0] EV_RESUMED  = 3'd3;
   localparam logic [2:0] EV_PROPS    = 3'd4;
   localparam logic [2:0] EV_TIME     = 3'd5;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  slot;
      logic [31:0] start_at;
      logic [31:0] stop_at;
      logic        start_known;
      logic        stop_known;
      logic [31:0] new_time;
      logic        paused;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  event_slot;
      logic [31:0] event_time;
      logic        last_event;
   } rsp_type;

endpackage

### rtl/timed_window_scheduler.sv
// Timed window scheduler: sorted pending and active timer queues under a sequencer.
//
// One request is taken at a time; req_stall stays high until the sequencer is idle,
// which is never before the last event of the request is in the output register.
// Cached window times and both queues live in RAMs with a registered read, so every
// queue step costs RAM round trips: a sorted insert reads the queue, reads the key
// and compares per element scanned, then reads and writes each element shifted; a
// removal reads and writes each element moved; an advance repeats the head check
// (queue read, key read, compare) plus a removal for every entry it retires, starts
// or drops and an insert for each one it starts. Each event waits in the output
// register until taken; the last one of a request carries last_event. event_time is
// the low 32 bits of the current time. There is no clearing pass: entry state is held
// in flip-flops cleared by reset, and RAM contents are read only for queued entries.
module timed_window_scheduler
   import tws_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int QW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int TW = TIME_BITS;

   typedef enum logic [1:0] {PL_NONE, PL_PENDING, PL_ACTIVE} place_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_REG, S_REG_EV, S_WD_EV, S_PZ_EV, S_PR_EV,
      S_INS_RDQ, S_INS_RDK, S_INS_CMP, S_SH_RD, S_SH_WR,
      S_RM_RD, S_RM_WR, S_FD_RD, S_FD_CMP,
      S_ADV_A, S_ADV_A_K, S_ADV_A_C, S_ADV_A_EV,
      S_ADV_P, S_ADV_P_K, S_ADV_P_C, S_ADV_P2, S_ADV_P_EV, S_ADV_T
   } state_type;

   state_type   state_ff, ret_ff;
   logic [2:0]  op_ff;
   logic [QW-1:0] who_ff, hd_ff, ins_who_ff;
   logic        slot_ok_ff;
   logic [TW-1:0] st_ff, sp_ff, t_ff, cur_ff, key_ff;
   logic        stok_ff, spok_ff, pz_ff;
   logic [CW-1:0] acnt_ff, pcnt_ff, idx_ff, pos_ff, j_ff;
   logic        qsel_ff;          // 0 active queue, 1 pending queue
   place_type   place_ff [ENTRIES];
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // RAM ports
   logic [QW-1:0] qaddr, kaddr, wq_addr, wq_data;
   logic          wq_en, w_en, q_sel_eff;
   logic [QW-1:0] aq_rd, pq_rd, q_rd;
   logic [TW-1:0] start_rd, stop_rd, k_rd;
   logic [CW-1:0] cnt_cur;
   logic          out_free, window_ok, will_start, rsp_load;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cnt_cur = qsel_ff ? pcnt_ff : acnt_ff;
   assign k_rd    = qsel_ff ? start_rd : stop_rd;
   assign q_rd    = q_sel_eff ? pq_rd : aq_rd;

   // register op outcome for a not-queued entry
   assign window_ok  = stok_ff && spok_ff && (st_ff < sp_ff) && (cur_ff < sp_ff);
   assign will_start = (place_ff[who_ff] == PL_NONE) && window_ok && (cur_ff >= st_ff);

   always_comb begin
      qaddr     = '0;
      kaddr     = '0;
      wq_en     = 1'b0;
      wq_addr   = '0;
      wq_data   = '0;
      w_en      = (state_ff == S_REG);
      q_sel_eff = qsel_ff;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_INS_RDQ: qaddr = idx_ff[QW-1:0];
         S_INS_RDK: kaddr = q_rd;
         S_SH_RD: begin
            if (j_ff > pos_ff) begin
               qaddr = QW'(j_ff - CW'(1));
            end else begin
               wq_en   = 1'b1;
               wq_addr = pos_ff[QW-1:0];
               wq_data = ins_who_ff;
            end
         end
         S_SH_WR: begin
            wq_en   = 1'b1;
            wq_addr = j_ff[QW-1:0];
            wq_data = q_rd;
         end
         S_RM_RD: qaddr = QW'(idx_ff + CW'(1));
         S_RM_WR: begin
            wq_en   = 1'b1;
            wq_addr = idx_ff[QW-1:0];
            wq_data = q_rd;
         end
         S_FD_RD: qaddr = idx_ff[QW-1:0];
         S_ADV_A: q_sel_eff = 1'b0;
         S_ADV_A_K: begin
            q_sel_eff = 1'b0;
            kaddr     = q_rd;
         end
         S_ADV_P: q_sel_eff = 1'b1;
         S_ADV_P_K: begin
            q_sel_eff = 1'b1;
            kaddr     = q_rd;
         end
         // event states load the output register when it is free
         S_PR_EV, S_REG_EV, S_WD_EV, S_PZ_EV, S_ADV_A_EV, S_ADV_P_EV, S_ADV_T:
            rsp_load = out_free;
         default: ;
      endcase
   end

   tws_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_start_ram (
      .clock, .wr_en(w_en), .wr_addr(who_ff), .wr_data(st_ff),
      .rd_addr(kaddr), .rd_data(start_rd));
   tws_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_stop_ram (
      .clock, .wr_en(w_en), .wr_addr(who_ff), .wr_data(sp_ff),
      .rd_addr(kaddr), .rd_data(stop_rd));
   tws_ram #(.WIDTH(QW), .DEPTH(ENTRIES)) u_active_ram (
      .clock, .wr_en(wq_en && !qsel_ff), .wr_addr(wq_addr), .wr_data(wq_data),
      .rd_addr(qaddr), .rd_data(aq_rd));
   tws_ram #(.WIDTH(QW), .DEPTH(ENTRIES)) u_pending_ram (
      .clock, .wr_en(wq_en && qsel_ff), .wr_addr(wq_addr), .wr_data(wq_data),
      .rd_addr(qaddr), .rd_data(pq_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         cur_ff       <= '0;
         acnt_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            place_ff[i] <= PL_NONE;
         end
      end else begin
         // taken event empties the register unless the next one lands now
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff      <= req_data.op;
                  who_ff     <= QW'(req_data.slot);
                  slot_ok_ff <= (32'(req_data.slot) < ENTRIES);
                  st_ff      <= TW'(req_data.start_at);
                  sp_ff      <= TW'(req_data.stop_at);
                  stok_ff    <= req_data.start_known;
                  spok_ff    <= req_data.stop_known;
                  t_ff       <= TW'(req_data.new_time);
                  pz_ff      <= req_data.paused;
                  state_ff   <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               idx_ff <= '0;
               unique case (op_ff)
                  OP_REGISTER: state_ff <= slot_ok_ff ? S_REG : S_IDLE;
                  OP_WITHDRAW: begin
                     if (slot_ok_ff && place_ff[who_ff] != PL_NONE) begin
                        qsel_ff          <= (place_ff[who_ff] == PL_PENDING);
                        ret_ff           <= (place_ff[who_ff] == PL_ACTIVE) ? S_WD_EV : S_IDLE;
                        place_ff[who_ff] <= PL_NONE;
                        state_ff         <= S_FD_RD;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  OP_ADVANCE: begin
                     if (t_ff > cur_ff) begin
                        cur_ff   <= t_ff;
                        qsel_ff  <= 1'b0;
                        state_ff <= S_ADV_A;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  OP_PAUSE: state_ff <= (slot_ok_ff && place_ff[who_ff] == PL_ACTIVE) ?
                                        S_PZ_EV : S_IDLE;
                  OP_PROPS: state_ff <= slot_ok_ff ? S_PR_EV : S_IDLE;
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_PR_EV: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{EV_PROPS, 4'(who_ff), 32'(cur_ff), !will_start};
                  state_ff     <= S_REG;
               end
            end
            S_REG: begin
               // caches are written this cycle; queued entries keep their place
               idx_ff     <= '0;
               ins_who_ff <= who_ff;
               if (place_ff[who_ff] == PL_NONE && window_ok) begin
                  if (cur_ff >= st_ff) begin
                     qsel_ff          <= 1'b0;
                     key_ff           <= sp_ff;
                     ret_ff           <= S_REG_EV;
                     place_ff[who_ff] <= PL_ACTIVE;
                  end else begin
                     qsel_ff          <= 1'b1;
                     key_ff           <= st_ff;
                     ret_ff           <= S_IDLE;
                     place_ff[who_ff] <= PL_PENDING;
                  end
                  state_ff <= S_INS_RDQ;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_REG_EV: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{EV_STARTED, 4'(who_ff), 32'(cur_ff), 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            S_WD_EV: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{EV_FINISHED, 4'(who_ff), 32'(cur_ff), 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            S_PZ_EV: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{pz_ff ? EV_PAUSED : EV_RESUMED, 4'(who_ff),
                                    32'(cur_ff), 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            // sorted insert: find first element with a larger key, then shift up
            S_INS_RDQ: begin
               if (idx_ff >= cnt_cur) begin
                  pos_ff   <= idx_ff;
                  j_ff     <= cnt_cur;
                  state_ff <= S_SH_RD;
               end else begin
                  state_ff <= S_INS_RDK;
               end
            end
            S_INS_RDK: state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               if (k_rd <= key_ff) begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_INS_RDQ;
               end else begin
                  pos_ff   <= idx_ff;
                  j_ff     <= cnt_cur;
                  state_ff <= S_SH_RD;
               end
            end
            S_SH_RD: begin
               if (j_ff > pos_ff) begin
                  state_ff <= S_SH_WR;
               end else begin
                  if (qsel_ff) pcnt_ff <= pcnt_ff + CW'(1);
                  else         acnt_ff <= acnt_ff + CW'(1);
                  state_ff <= ret_ff;
               end
            end
            S_SH_WR: begin
               j_ff     <= j_ff - CW'(1);
               state_ff <= S_SH_RD;
            end
            // removal at idx: pull later elements down
            S_RM_RD: begin
               if (idx_ff + CW'(1) < cnt_cur) begin
                  state_ff <= S_RM_WR;
               end else begin
                  if (qsel_ff) pcnt_ff <= pcnt_ff - CW'(1);
                  else         acnt_ff <= acnt_ff - CW'(1);
                  state_ff <= ret_ff;
               end
            end
            S_RM_WR: begin
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_RM_RD;
            end
            S_FD_RD: state_ff <= S_FD_CMP;
            S_FD_CMP: begin
               if (q_rd == who_ff) begin
                  state_ff <= S_RM_RD;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_FD_RD;
               end
            end
            // advance: retire expired active heads
            S_ADV_A: state_ff <= (acnt_ff == '0) ? S_ADV_P : S_ADV_A_K;
            S_ADV_A_K: begin
               hd_ff    <= q_rd;
               state_ff <= S_ADV_A_C;
            end
            S_ADV_A_C: state_ff <= (cur_ff < stop_rd) ? S_ADV_P : S_ADV_A_EV;
            S_ADV_A_EV: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_data_ff     <= '{EV_FINISHED, 4'(hd_ff), 32'(cur_ff), 1'b0};
                  place_ff[hd_ff] <= PL_NONE;
                  qsel_ff         <= 1'b0;
                  idx_ff          <= '0;
                  ret_ff          <= S_ADV_A;
                  state_ff        <= S_RM_RD;
               end
            end
            // advance: start due pending heads, drop stale ones
            S_ADV_P: state_ff <= (pcnt_ff == '0) ? S_ADV_T : S_ADV_P_K;
            S_ADV_P_K: begin
               hd_ff    <= q_rd;
               state_ff <= S_ADV_P_C;
            end
            S_ADV_P_C: begin
               if (cur_ff < start_rd) begin
                  state_ff <= S_ADV_T;
               end else begin
                  key_ff          <= stop_rd;
                  place_ff[hd_ff] <= PL_NONE;
                  qsel_ff         <= 1'b1;
                  idx_ff          <= '0;
                  ret_ff          <= S_ADV_P2;
                  state_ff        <= S_RM_RD;
               end
            end
            S_ADV_P2: begin
               if (cur_ff < key_ff) begin
                  place_ff[hd_ff] <= PL_ACTIVE;
                  qsel_ff         <= 1'b0;
                  ins_who_ff      <= hd_ff;
                  idx_ff          <= '0;
                  ret_ff          <= S_ADV_P_EV;
                  state_ff        <= S_INS_RDQ;
               end else begin
                  state_ff <= S_ADV_P;
               end
            end
            S_ADV_P_EV: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{EV_STARTED, 4'(hd_ff), 32'(cur_ff), 1'b0};
                  state_ff     <= S_ADV_P;
               end
            end
            S_ADV_T: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{EV_TIME, 4'd0, 32'(cur_ff), 1'b1};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### rtl/tws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/tws_checker.sv
// Port-level checker for the timed window scheduler, bound to the top level.
module tws_checker
   import tws_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled event changed");

   a_time_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_TIME |->
         rsp_data.last_event && rsp_data.event_slot == 4'd0)
      else $error("time event not final or slot nonzero");

   a_busy_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_event |=> req_stall)
      else $error("request taken before its last event");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");
endmodule

bind timed_window_scheduler tws_checker u_tws_checker (.*);

### test/testbench.sv
// Self-checking testbench of the timed window scheduler: driver, monitor, event predictor.
module testbench;
   import tws_pkg::*;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 10000000;
   localparam logic [1:0] SLOT_FREE = 2'd0;
   localparam logic [1:0] SLOT_WAITING = 2'd1;
   localparam logic [1:0] SLOT_RUNNING = 2'd2;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   timed_window_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Predictor state: the scheduler's clock, cached windows and both sorted queues.
   logic [31:0] sim_now;
   logic [31:0] win_start [SLOTS];
   logic [31:0] win_stop [SLOTS];
   logic [1:0]  slot_place [SLOTS];
   int          run_queue[$];
   int          wait_queue[$];

   req_type pending_reqs[$];
   rsp_type expected_events[$];
   rsp_type new_events[$];

   int  errors = 0;
   int  cycles = 0;
   int  reqs_sent = 0;
   int  events_seen = 0;
   int  send_wait = 0;
   int  take_wait = 0;
   bit  hold_send = 0;
   bit  stim_done = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic void note(logic [2:0] kind, int who);
      rsp_type e;
      e.event_kind = kind;
      e.event_slot = who[3:0];
      e.event_time = sim_now;
      e.last_event = 1'b0;
      new_events.push_back(e);
   endfunction

   // Sorted insert: the new slot goes behind all slots with a key <= its own.
   function automatic void insert_sorted(ref int q[$], input bit by_stop, input int who);
      int pos;
      logic [31:0] key;
      key = by_stop ? win_stop[who] : win_start[who];
      pos = 0;
      while (pos < q.size() &&
             (by_stop ? win_stop[q[pos]] : win_start[q[pos]]) <= key)
         pos++;
      q.insert(pos, who);
   endfunction

   function automatic void remove_slot(ref int q[$], input int who);
      foreach (q[i]) if (q[i] == who) begin
         q.delete(i);
         return;
      end
   endfunction

   function automatic void enroll(int who, logic [31:0] st, logic [31:0] sp,
                                  logic st_ok, logic sp_ok);
      win_start[who] = st;
      win_stop[who] = sp;
      if (slot_place[who] != SLOT_FREE) return;
      if (!st_ok || !sp_ok || !(st < sp) || sim_now >= sp) return;
      if (sim_now >= st) begin
         insert_sorted(run_queue, 1, who);
         slot_place[who] = SLOT_RUNNING;
         note(EV_STARTED, who);
      end else begin
         insert_sorted(wait_queue, 0, who);
         slot_place[who] = SLOT_WAITING;
      end
   endfunction

   function automatic void predict_events(req_type r);
      int who;
      who = r.slot;
      new_events.delete();
      case (r.op)
         OP_REGISTER: enroll(who, r.start_at, r.stop_at, r.start_known, r.stop_known);
         OP_WITHDRAW: begin
            if (slot_place[who] == SLOT_RUNNING) begin
               remove_slot(run_queue, who);
               slot_place[who] = SLOT_FREE;
               note(EV_FINISHED, who);
            end else if (slot_place[who] == SLOT_WAITING) begin
               remove_slot(wait_queue, who);
               slot_place[who] = SLOT_FREE;
            end
         end
         OP_ADVANCE: if (r.new_time > sim_now) begin
            sim_now = r.new_time;
            // expiry sweep first, then due pending entries, then the time notice
            while (run_queue.size() > 0 && sim_now >= win_stop[run_queue[0]]) begin
               note(EV_FINISHED, run_queue[0]);
               slot_place[run_queue[0]] = SLOT_FREE;
               run_queue.delete(0);
            end
            while (wait_queue.size() > 0 && sim_now >= win_start[wait_queue[0]]) begin
               who = wait_queue[0];
               wait_queue.delete(0);
               slot_place[who] = SLOT_FREE;
               if (sim_now < win_stop[who]) begin
                  insert_sorted(run_queue, 1, who);
                  slot_place[who] = SLOT_RUNNING;
                  note(EV_STARTED, who);
               end
            end
            note(EV_TIME, 0);
         end
         OP_PAUSE: if (slot_place[who] == SLOT_RUNNING)
            note(r.paused ? EV_PAUSED : EV_RESUMED, who);
         OP_PROPS: begin
            note(EV_PROPS, who);
            enroll(who, r.start_at, r.stop_at, r.start_known, r.stop_known);
         end
         default: ;
      endcase
      if (new_events.size() > 0) new_events[new_events.size() - 1].last_event = 1'b1;
      foreach (new_events[i]) expected_events.push_back(new_events[i]);
   endfunction

   // Driver: one transfer per accepted request, random gap between requests.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_events(req_data);
            reqs_sent <= reqs_sent + 1;
         end
         if (req_valid && req_stall) begin
            // hold the stalled payload
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !hold_send &&
                      !(pending_reqs[0].op == 3'd7 && expected_events.size() > 0)) begin
            req_data <= pending_reqs[0];
            pending_reqs.delete(0);
            req_valid <= 1'b1;
            send_wait <= $urandom_range(0, 9);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each event transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            events_seen <= events_seen + 1;
            if (expected_events.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected event %p", rsp_data);
            end else begin
               if (rsp_data !== expected_events[0]) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("event mismatch: expected %p actual %p",
                              expected_events[0], rsp_data);
               end
               expected_events.delete(0);
            end
         end
         if (take_wait > 0) begin
            take_wait <= take_wait - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid) take_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
         end
      end
   end

   function automatic req_type make_req(logic [2:0] op, logic [3:0] slot,
                                        logic [31:0] st, logic [31:0] sp,
                                        logic sk, logic pk, logic [31:0] t, logic pz);
      req_type r;
      r.op = op; r.slot = slot; r.start_at = st; r.stop_at = sp;
      r.start_known = sk; r.stop_known = pk; r.new_time = t; r.paused = pz;
      return r;
   endfunction

   // Random request biased toward well-formed windows near the stimulus clock.
   function automatic req_type random_req(ref logic [31:0] clk);
      req_type r;
      int pick;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 8) begin                                  // raw noise
         if (r.op == OP_ADVANCE && r.new_time > clk) clk = r.new_time;
         return r;
      end
      r.start_known = ($urandom_range(0, 9) != 0);
      r.stop_known = ($urandom_range(0, 9) != 0);
      r.start_at = clk + $urandom_range(0, 60) - 10;
      r.stop_at = r.start_at + $urandom_range(0, 80) - 5;
      if (pick < 40) r.op = OP_REGISTER;
      else if (pick < 55) r.op = OP_WITHDRAW;
      else if (pick < 78) begin
         r.op = OP_ADVANCE;
         r.new_time = clk + $urandom_range(0, 30) - 3;
         if (r.new_time > clk) clk = r.new_time;
      end else if (pick < 90) r.op = OP_PAUSE;
      else r.op = OP_PROPS;
      return r;
   endfunction

   initial begin
      logic [31:0] clk;
      int idle_cnt;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data = '0;
      sim_now = '0;
      foreach (slot_place[i]) slot_place[i] = SLOT_FREE;
      // directed: field extremes, every op, equal keys, invalid and expired windows
      pending_reqs.push_back(make_req(OP_REGISTER, 0, 0, 32'hFFFFFFFF, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 1, 10, 20, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 2, 10, 20, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 3, 10, 10, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 4, 5, 30, 0, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 5, 5, 30, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 15, 12, 14, 1, 1, 0, 1));
      pending_reqs.push_back(make_req(OP_REGISTER, 1, 11, 25, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_PAUSE, 0, 0, 0, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_PAUSE, 2, 0, 0, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_ADVANCE, 0, 0, 0, 0, 0, 16, 0));
      pending_reqs.push_back(make_req(OP_PROPS, 7, 16, 40, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_PROPS, 1, 3, 4, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 8, 2, 15, 1, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_WITHDRAW, 2, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_WITHDRAW, 9, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(OP_ADVANCE, 0, 0, 0, 0, 0, 40, 0));
      pending_reqs.push_back(make_req(3'd5, 3, 0, 0, 1, 1, 99, 1));
      pending_reqs.push_back(make_req(3'd7, 3, 0, 0, 1, 1, 99, 1));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_valid && expected_events.size() == 0);
      repeat (200) @(posedge clock);
      // random phase: windows and advances relative to the predictor's clock
      clk = sim_now;
      for (int i = 0; i < 320; i++) begin
         if (clk > 32'hFFFFF000) clk = sim_now;
         pending_reqs.push_back(random_req(clk));
         if (i == 160) begin
            wait (pending_reqs.size() == 0);
            @(posedge clock);
            hold_send = 1;
            wait (!req_valid && expected_events.size() == 0);
            hold_send = 0;
         end
      end
      wait (pending_reqs.size() == 0);
      // top of the time range last: jump to the maximum, then a window already over
      pending_reqs.push_back(make_req(OP_ADVANCE, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0));
      pending_reqs.push_back(make_req(OP_REGISTER, 0, 0, 32'hFFFFFFFF, 1, 1, 0, 0));
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_valid && expected_events.size() == 0);
      idle_cnt = 0;
      while (idle_cnt < 400) begin
         @(posedge clock);
         idle_cnt++;
      end
      stim_done = 1;
   end

   // End of run: summary and verdict, or a timeout.
   always @(posedge clock) begin
      if (stim_done) begin
         $display("ran %0d requests and checked %0d events over %0d cycles",
                  reqs_sent, events_seen, cycles);
         $display("covered register, withdraw, advance, pause, properties and noise ops");
         if (errors == 0 && expected_events.size() == 0)
            $display("timed_window_scheduler: match");
         else
            $display("timed_window_scheduler: mismatch");
         $finish;
      end else if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("timed_window_scheduler: mismatch");
         $finish;
      end
   end

endmodule

### filelist.f
rtl/tws_pkg.sv
rtl/tws_ram.sv
rtl/timed_window_scheduler.sv
rtl/tws_checker.sv
test/testbench.sv
